### hw/rtl/rgbis_pkg.sv
// Shared types and constants for the RGB interpolation sampler.
// No dependencies; imported by the sampler top level.
package rgbis_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int PIX_W   = 24;
    localparam int COORD_W = 16;
    localparam int OUT_W   = 16;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 2;
    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFF00;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd2;

    // item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // interpolation modes
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_CUBIC  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_WGT,
        S_TAP,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

### hw/rtl/rgb_image_interpolation_sampler.sv
// RGB pixel store with bilinear / bicubic sampling.
// A write word is taken while idle; the block stays idle and ready for the next word.
// A sample walks the weight states S_MUL1, S_MUL2 and S_WGT, one RAM read per tap (4 bilinear,
// 16 bicubic), a drain and an output state that waits while the output stalls; no new word is taken until idle.
// Reset (synchronous, active low) clears control state and sets the registers to
// width 256, height 256, bilinear; the pixel store is not cleared.
module rgb_image_interpolation_sampler
    import rgbis_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [15:0]        i_pixel_addr,
    input  logic [7:0]         i_wr_red,
    input  logic [7:0]         i_wr_green,
    input  logic [7:0]         i_wr_blue,
    input  logic [COORD_W-1:0] i_coord_x,
    input  logic [COORD_W-1:0] i_coord_y,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [OUT_W-1:0]   o_out_red,
    output logic [OUT_W-1:0]   o_out_green,
    output logic [OUT_W-1:0]   o_out_blue,
    output logic               o_edge_clamped,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int F      = FRAC_BITS;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W  = $clog2(MAXD + 1);
    localparam int INT_W  = COORD_W - F;
    localparam int CV_W   = COORD_W + 2;
    localparam int W3     = 3 * F + 3;
    localparam int WGT_W  = W3 - F;
    localparam int TW_W   = 2 * WGT_W;
    localparam int PP_W   = TW_W + 9;
    localparam int ACC_W  = PP_W + 4;
    localparam int SH_LIN = 2 * F - 8;
    localparam int SH_CUB = 4 * F - 8;
    localparam logic [ACC_W-1:0] RND_LIN =
        (SH_LIN > 0) ? (ACC_W'(1) << ((SH_LIN > 0) ? SH_LIN - 1 : 0)) : '0;
    localparam logic [ACC_W-1:0] RND_CUB = ACC_W'(1) << (SH_CUB - 1);
    localparam logic [F:0]  S_ONE = (F + 1)'(1) << F;

    // round a weight from scale S^3 to S^2
    function automatic logic signed [WGT_W-1:0] round_w(input logic [W3-1:0] w);
        logic signed [W3-1:0] t;
        t = $signed(w + (W3'(1) << (F - 1)));
        return WGT_W'(t >>> F);
    endfunction

    // clamp, round and saturate one channel sum
    function automatic logic [OUT_W-1:0] to_out(input logic signed [ACC_W-1:0] a,
                                                input logic cubic);
        logic [ACC_W-1:0] u;
        if (a < 0) begin
            return '0;
        end
        u = cubic ? ((ACC_W'(a) + RND_CUB) >> SH_CUB) : ((ACC_W'(a) + RND_LIN) >> SH_LIN);
        return (u > ACC_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(u);
    endfunction

    // effective image dimension
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r, input int mx);
        if (r == '0) begin
            return DIM_W'(1);
        end
        if (32'(r) > mx) begin
            return DIM_W'(mx);
        end
        return DIM_W'(r);
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_width, r_cfg_height;
    logic             r_cfg_mode;

    logic                r_mode;
    logic [DIM_W-1:0]    r_w, r_h;
    logic [INT_W-1:0]    r_xi, r_yi;
    logic [F-1:0]        r_px, r_py;
    logic [2*F-1:0]      r_ppx, r_ppy;
    logic [2*F+1:0]      r_qqx, r_qqy;
    logic [W3-1:0]       r_pqqx, r_pppx, r_qqqx, r_qppx;
    logic [W3-1:0]       r_pqqy, r_pppy, r_qqqy, r_qppy;
    logic signed [WGT_W-1:0] r_wx [4];
    logic signed [WGT_W-1:0] r_wy [4];
    logic [3:0]          r_k;
    logic signed [TW_W-1:0]  r_tw;
    logic                r_tv;
    logic signed [ACC_W-1:0] r_acc [3];
    logic                r_flag;

    logic [F:0]       qx, qy;
    logic             in_acc, wr_acc, smp_acc, ram_we, last_tap, out_free;
    logic [1:0]       ii, jj;
    logic signed [CV_W-1:0] cvx, cvy, first;
    logic [DIM_W-1:0] col, row;
    logic             clx, cly;
    logic [ADDR_W-1:0] tap_addr, ram_addr;
    logic [PIX_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign wr_acc  = in_acc && (i_op == OP_WRITE);
    assign smp_acc = in_acc && (i_op == OP_SAMPLE);
    assign ram_we  = wr_acc && (32'(i_pixel_addr) < DEPTH);
    assign out_free = !(o_out_valid && i_out_stall);
    assign qx = S_ONE - (F + 1)'(r_px);
    assign qy = S_ONE - (F + 1)'(r_py);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(256);
            r_cfg_height <= CFG_W'(256);
            r_cfg_mode   <= MODE_LINEAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_MODE:   r_cfg_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // tap index and neighbour coordinates
    always_comb begin
        if (r_mode == MODE_CUBIC) begin
            ii    = r_k[1:0];
            jj    = r_k[3:2];
            first = -CV_W'(1);
            last_tap = (r_k == 4'd15);
        end else begin
            ii    = {1'b0, r_k[0]};
            jj    = {1'b0, r_k[1]};
            first = '0;
            last_tap = (r_k == 4'd3);
        end
        cvx = $signed(CV_W'(r_xi)) + $signed(CV_W'(ii)) + first;
        cvy = $signed(CV_W'(r_yi)) + $signed(CV_W'(jj)) + first;
        clx = 1'b1;
        cly = 1'b1;
        if (cvx < 0) begin
            col = '0;
        end else if (cvx >= $signed(CV_W'(r_w))) begin
            col = r_w - DIM_W'(1);
        end else begin
            col = DIM_W'(cvx);
            clx = 1'b0;
        end
        if (cvy < 0) begin
            row = '0;
        end else if (cvy >= $signed(CV_W'(r_h))) begin
            row = r_h - DIM_W'(1);
        end else begin
            row = DIM_W'(cvy);
            cly = 1'b0;
        end
        tap_addr = ADDR_W'(row * r_w + (2 * DIM_W)'(col));
        ram_addr = (r_state == S_IDLE) ? ADDR_W'(i_pixel_addr) : tap_addr;
    end

    rgbis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_wr_red, i_wr_green, i_wr_blue}),
        .o_rdata (ram_rdata)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (smp_acc) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_WGT;
            S_WGT:   n_state = S_TAP;
            S_TAP:   n_state = last_tap ? S_DRAIN : S_TAP;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath: latch sample, form weights, walk taps, accumulate
    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_mode <= r_cfg_mode;
            r_w    <= eff_dim(r_cfg_width, MAX_WIDTH);
            r_h    <= eff_dim(r_cfg_height, MAX_HEIGHT);
            r_xi   <= i_coord_x[COORD_W-1:F];
            r_yi   <= i_coord_y[COORD_W-1:F];
            r_px   <= i_coord_x[F-1:0];
            r_py   <= i_coord_y[F-1:0];
        end
        if (r_state == S_MUL1) begin
            r_ppx <= r_px * r_px;
            r_ppy <= r_py * r_py;
            r_qqx <= qx * qx;
            r_qqy <= qy * qy;
        end
        if (r_state == S_MUL2) begin
            r_pqqx <= W3'(r_px * r_qqx);
            r_pppx <= W3'(r_px * r_ppx);
            r_qqqx <= W3'(qx * r_qqx);
            r_qppx <= W3'(qx * r_ppx);
            r_pqqy <= W3'(r_py * r_qqy);
            r_pppy <= W3'(r_py * r_ppy);
            r_qqqy <= W3'(qy * r_qqy);
            r_qppy <= W3'(qy * r_ppy);
        end
        if (r_state == S_WGT) begin
            if (r_mode == MODE_CUBIC) begin
                r_wx[0] <= round_w(-r_pqqx);
                r_wx[1] <= round_w(r_pppx - (W3'(r_ppx) << (F + 1)) + (W3'(1) << (3 * F)));
                r_wx[2] <= round_w(r_qqqx - (W3'(r_qqx) << (F + 1)) + (W3'(1) << (3 * F)));
                r_wx[3] <= round_w(-r_qppx);
                r_wy[0] <= round_w(-r_pqqy);
                r_wy[1] <= round_w(r_pppy - (W3'(r_ppy) << (F + 1)) + (W3'(1) << (3 * F)));
                r_wy[2] <= round_w(r_qqqy - (W3'(r_qqy) << (F + 1)) + (W3'(1) << (3 * F)));
                r_wy[3] <= round_w(-r_qppy);
            end else begin
                r_wx[0] <= $signed(WGT_W'(qx));
                r_wx[1] <= $signed(WGT_W'(r_px));
                r_wx[2] <= '0;
                r_wx[3] <= '0;
                r_wy[0] <= $signed(WGT_W'(qy));
                r_wy[1] <= $signed(WGT_W'(r_py));
                r_wy[2] <= '0;
                r_wy[3] <= '0;
            end
        end
        // issue one tap: RAM read and combined weight
        r_tw <= r_wx[ii] * r_wy[jj];
        if (r_state == S_TAP) begin
            r_k    <= r_k + 4'd1;
            r_flag <= r_flag | clx | cly;
        end else begin
            r_k <= '0;
        end
        if (smp_acc) begin
            r_flag <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
            end
        end else if (r_tv) begin
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= r_acc[c] + ACC_W'(r_tw * $signed({1'b0,
                            ram_rdata[PIX_W-1-8*c -: 8]}));
            end
        end
    end

    // tap valid and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_tv <= (r_state == S_TAP);
            if (r_state == S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_out_red      <= to_out(r_acc[0], r_mode);
            o_out_green    <= to_out(r_acc[1], r_mode);
            o_out_blue     <= to_out(r_acc[2], r_mode);
            o_edge_clamped <= r_flag;
        end
    end

    // a fresh result only follows the output cycle
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside output cycle");

    // store writes only happen while idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == S_IDLE)
        else $error("store write during sample");

    // accumulation only follows a tap issue
    a_tap_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv |-> (r_state == S_TAP || r_state == S_DRAIN))
        else $error("tap accumulate outside tap walk");

endmodule

### hw/rtl/rgbis_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rgbis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and read one word per cycle; a read of the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
